// ===== rtl/trt_pkg.sv =====
// ----------------------------------------------------------------------------
// trt_pkg
// Shared types and codes of the texture residency table.
// ----------------------------------------------------------------------------
package trt_pkg;

	localparam int ACTION_W  = 3;
	localparam int STATUS_W  = 3;
	localparam int TEX_W     = 32;
	localparam int HANDLE_W  = 64;
	localparam int AGE_W     = 16;
	localparam int ORDER_W   = 32;

	// request actions
	localparam logic [ACTION_W-1:0] ACT_BIND          = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_QUERY         = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_UNBIND_ID     = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_UNBIND_HANDLE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_UNBIND_ALL    = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_TICK          = 3'd5;

	// response status codes
	localparam logic [STATUS_W-1:0] STS_DONE    = 3'd0;
	localparam logic [STATUS_W-1:0] STS_HIT     = 3'd1;
	localparam logic [STATUS_W-1:0] STS_NEW     = 3'd2;
	localparam logic [STATUS_W-1:0] STS_REMOVED = 3'd3;
	localparam logic [STATUS_W-1:0] STS_FAIL    = 3'd4;

	localparam logic [AGE_W-1:0] AGE_SAT = {AGE_W{1'b1}};

	// one stored binding
	typedef struct packed {
		logic [TEX_W-1:0]    texture;
		logic [HANDLE_W-1:0] handle;
		logic [AGE_W-1:0]    age;
		logic                pinned;
		logic [ORDER_W-1:0]  order;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/trt_if.sv =====
// ----------------------------------------------------------------------------
// trt_req_if / trt_rsp_if
// Valid/ready channels for requests into and results out of the table.
// ----------------------------------------------------------------------------
interface trt_req_if import trt_pkg::*;;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [TEX_W-1:0]    texture_id;
	logic [HANDLE_W-1:0] new_handle;
	logic                pin;
	logic                include_pinned;

	modport source (output valid, action, texture_id, new_handle, pin, include_pinned,
		input ready);
	modport sink (input valid, action, texture_id, new_handle, pin, include_pinned,
		output ready);
endinterface

interface trt_rsp_if import trt_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] out_handle;
	logic [TEX_W-1:0]    out_texture_id;
	logic                last;

	modport source (output valid, status, out_handle, out_texture_id, last, input ready);
	modport sink (input valid, status, out_handle, out_texture_id, last, output ready);
endinterface

// ===== rtl/trt_ram.sv =====
// ----------------------------------------------------------------------------
// trt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/texture_residency_table_core.sv =====
// ----------------------------------------------------------------------------
// texture_residency_table_core
// Age-based eviction table of texture bindings with pinning.
// ----------------------------------------------------------------------------
// Results: bind, query and unbind raise their result after a scan of all slots
//   that follows the request; an evicting bind raises its second after the first is taken.
// Unbind-all and tick run a marking pass, then one drain pass per removed entry
//   plus a final one, each after the prior result.
// Throughput: one request at a time; the next is taken after the last result.
// Reset (arst_n low): entries invalid, insert counter and max_age cleared; ready.
module texture_residency_table_core import trt_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [AGE_W-1:0] cfg_wr_data,
	trt_req_if.sink          req,
	trt_rsp_if.source        rsp
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_INS    = 7'b0001000,
		S_DSCAN  = 7'b0010000,
		S_DPICK  = 7'b0100000,
		S_WAIT   = 7'b1000000
	} state_t;

	state_t state_q, ret_q;

	// latched request
	logic [ACTION_W-1:0] op_q;
	logic [TEX_W-1:0]    tid_q;
	logic [HANDLE_W-1:0] hnd_q;
	logic                pin_q;
	logic                incl_q;

	logic [AGE_W-1:0]    max_age_q;
	logic [ORDER_W-1:0]  ins_cnt_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [ENTRIES-1:0]  mark_q;

	// scan walker and RAM read stage
	logic [CW-1:0] cnt_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;

	// scan results
	logic               hit_found_q;
	logic [IW-1:0]      hit_idx_q;
	entry_t             hit_word_q;
	logic [ORDER_W-1:0] hit_dist_q;
	logic               free_found_q;
	logic [IW-1:0]      free_idx_q;
	logic               vic_found_q;
	logic [IW-1:0]      vic_idx_q;
	entry_t             vic_word_q;
	logic [ORDER_W-1:0] vic_dist_q;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [TEX_W-1:0]    out_tid_q;
	logic                out_last_q;

	// RAM port
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	entry_t             ram_wdata;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;

	entry_t             rd_word;
	logic [ORDER_W-1:0] cur_dist;
	logic               cur_valid;
	logic               scan_last;
	entry_t             new_word;
	entry_t             aged_word;
	entry_t             hit_zero;

	// result about to be loaded into the output register
	logic                em_valid;
	logic [STATUS_W-1:0] em_status;
	logic [HANDLE_W-1:0] em_handle;
	logic [TEX_W-1:0]    em_tid;
	logic                em_last;
	state_t              em_ret;

	// scan-stage qualifiers
	logic id_hit, hnd_hit, take_hit, take_free, take_vic, drain_take;

	trt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (cnt_q[IW-1:0]),
		.rd_data (ram_rdata)
	);

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.out_handle     = out_handle_q;
	assign rsp.out_texture_id = out_tid_q;
	assign rsp.last           = out_last_q;

	// Walk the slots one per cycle in both scan passes.
	assign ram_re    = ((state_q == S_SCAN) || (state_q == S_DSCAN)) && (cnt_q != CNT_END);
	assign rd_word   = entry_t'(ram_rdata);
	// Distance from the insert counter: larger means inserted earlier.
	assign cur_dist  = ins_cnt_q - rd_word.order;
	assign cur_valid = valid_q[rd_idx_s1];
	assign scan_last = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);

	always_comb begin
		new_word         = '0;
		new_word.texture = tid_q;
		new_word.handle  = hnd_q;
		new_word.age     = '0;
		new_word.pinned  = pin_q;
		new_word.order   = ins_cnt_q;
		aged_word        = rd_word;
		if (rd_word.age != AGE_SAT) begin
			aged_word.age = rd_word.age + AGE_W'(1);
		end
		hit_zero     = hit_word_q;
		hit_zero.age = '0;
	end

	// Per-slot compare of the shared scan unit.
	always_comb begin
		id_hit    = cur_valid && (rd_word.texture == tid_q);
		hnd_hit   = cur_valid && (rd_word.handle == hnd_q);
		take_hit  = 1'b0;
		if (op_q == ACT_UNBIND_HANDLE) begin
			// earliest inserted among equal handles
			take_hit = hnd_hit && (!hit_found_q || (cur_dist > hit_dist_q));
		end else begin
			take_hit = id_hit && !hit_found_q;
		end
		take_free = !cur_valid && !free_found_q;
		// oldest unpinned, later-inserted on equal age
		take_vic  = !rd_word.pinned && (!vic_found_q || (rd_word.age > vic_word_q.age) ||
			((rd_word.age == vic_word_q.age) && (cur_dist < vic_dist_q)));
		drain_take = mark_q[rd_idx_s1] && (!hit_found_q || (cur_dist > hit_dist_q));
	end

	// RAM writes: age update on tick, refresh or insert on bind.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_idx_s1;
		ram_wdata = aged_word;
		if ((state_q == S_SCAN) && rd_vld_s1 && (op_q == ACT_TICK) && cur_valid) begin
			ram_we = 1'b1;
		end else if ((state_q == S_DECIDE) && (op_q == ACT_BIND)) begin
			if (hit_found_q) begin
				ram_we    = 1'b1;
				ram_waddr = hit_idx_q;
				ram_wdata = hit_zero;
			end else if (free_found_q) begin
				ram_we    = 1'b1;
				ram_waddr = free_idx_q;
				ram_wdata = new_word;
			end else if (vic_found_q) begin
				ram_we    = 1'b1;
				ram_waddr = vic_idx_q;
				ram_wdata = new_word;
			end
		end
	end

	// Result selection.
	always_comb begin
		em_valid  = 1'b0;
		em_status = STS_DONE;
		em_handle = '0;
		em_tid    = '0;
		em_last   = 1'b1;
		em_ret    = S_IDLE;
		unique case (state_q)
			S_DECIDE: begin
				em_valid = 1'b1;
				unique case (op_q) inside
					ACT_BIND: begin
						em_tid = tid_q;
						if (hit_found_q) begin
							em_status = STS_HIT;
							em_handle = hit_word_q.handle;
						end else if (free_found_q) begin
							em_status = STS_NEW;
							em_handle = hnd_q;
						end else if (vic_found_q) begin
							em_status = STS_REMOVED;
							em_handle = vic_word_q.handle;
							em_tid    = vic_word_q.texture;
							em_last   = 1'b0;
							em_ret    = S_INS;
						end else begin
							em_status = STS_FAIL;
						end
					end
					ACT_QUERY: begin
						em_tid    = tid_q;
						em_status = hit_found_q ? STS_HIT : STS_NEW;
						em_handle = hit_found_q ? hit_word_q.handle : '0;
					end
					ACT_UNBIND_ID, ACT_UNBIND_HANDLE: begin
						if (hit_found_q) begin
							em_status = STS_REMOVED;
							em_handle = hit_word_q.handle;
							em_tid    = hit_word_q.texture;
						end else begin
							em_status = STS_NEW;
							em_tid    = (op_q == ACT_UNBIND_ID) ? tid_q : '0;
						end
					end
					ACT_UNBIND_ALL, ACT_TICK: begin
						em_valid = 1'b0;
					end
					default: begin
						em_status = STS_DONE;
					end
				endcase
			end
			S_INS: begin
				em_valid  = 1'b1;
				em_status = STS_NEW;
				em_handle = hnd_q;
				em_tid    = tid_q;
			end
			S_DPICK: begin
				em_valid = 1'b1;
				if (hit_found_q) begin
					em_status = STS_REMOVED;
					em_handle = hit_word_q.handle;
					em_tid    = hit_word_q.texture;
					em_last   = 1'b0;
					em_ret    = S_DSCAN;
				end
			end
			default: begin
				em_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			max_age_q    <= '0;
			ins_cnt_q    <= '0;
			valid_q      <= '0;
			mark_q       <= '0;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_age_q <= cfg_wr_data;
			end

			// advance the read walker
			rd_vld_s1 <= ram_re;
			if (ram_re) begin
				cnt_q <= cnt_q + CW'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q      <= S_SCAN;
						cnt_q        <= '0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						vic_found_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (rd_vld_s1) begin
						if (take_hit) begin
							hit_found_q <= 1'b1;
						end
						if (take_free) begin
							free_found_q <= 1'b1;
						end
						if (take_vic) begin
							vic_found_q <= 1'b1;
						end
						// mark the slots a drain pass removes
						if (op_q == ACT_UNBIND_ALL) begin
							mark_q[rd_idx_s1] <= cur_valid && (!rd_word.pinned || incl_q);
						end else if (op_q == ACT_TICK) begin
							mark_q[rd_idx_s1] <= cur_valid && !rd_word.pinned &&
								(rd_word.age >= max_age_q);
						end else begin
							mark_q[rd_idx_s1] <= 1'b0;
						end
					end
					if (scan_last) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					unique case (op_q) inside
						ACT_BIND: begin
							if (!hit_found_q && free_found_q) begin
								valid_q[free_idx_q] <= 1'b1;
								ins_cnt_q           <= ins_cnt_q + ORDER_W'(1);
							end else if (!hit_found_q && vic_found_q) begin
								ins_cnt_q <= ins_cnt_q + ORDER_W'(1);
							end
						end
						ACT_UNBIND_ID, ACT_UNBIND_HANDLE: begin
							if (hit_found_q) begin
								valid_q[hit_idx_q] <= 1'b0;
							end
						end
						ACT_UNBIND_ALL, ACT_TICK: begin
							state_q     <= S_DSCAN;
							cnt_q       <= '0;
							hit_found_q <= 1'b0;
						end
						default: begin
						end
					endcase
				end
				S_DSCAN: begin
					if (rd_vld_s1 && drain_take) begin
						hit_found_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= S_DPICK;
					end
				end
				S_DPICK: begin
					// drop the earliest marked entry, then rescan
					if (hit_found_q) begin
						valid_q[hit_idx_q] <= 1'b0;
						mark_q[hit_idx_q]  <= 1'b0;
						cnt_q              <= '0;
						hit_found_q        <= 1'b0;
					end
				end
				S_INS: begin
				end
				S_WAIT: begin
					if (rsp.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (em_valid) begin
				out_valid_q <= 1'b1;
				state_q     <= S_WAIT;
				ret_q       <= em_ret;
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.action;
			tid_q  <= req.texture_id;
			hnd_q  <= req.new_handle;
			pin_q  <= req.pin;
			incl_q <= req.include_pinned;
		end
		rd_idx_s1 <= cnt_q[IW-1:0];
		if ((state_q == S_SCAN) && rd_vld_s1) begin
			if (take_hit) begin
				hit_idx_q  <= rd_idx_s1;
				hit_word_q <= rd_word;
				hit_dist_q <= cur_dist;
			end
			if (take_free) begin
				free_idx_q <= rd_idx_s1;
			end
			if (take_vic) begin
				vic_idx_q  <= rd_idx_s1;
				vic_word_q <= rd_word;
				vic_dist_q <= cur_dist;
			end
		end
		if ((state_q == S_DSCAN) && rd_vld_s1 && drain_take) begin
			hit_idx_q  <= rd_idx_s1;
			hit_word_q <= rd_word;
			hit_dist_q <= cur_dist;
		end
		if (em_valid) begin
			out_status_q <= em_status;
			out_handle_q <= em_handle;
			out_tid_q    <= em_tid;
			out_last_q   <= em_last;
		end
	end

endmodule

// ===== rtl/trt_checker.sv =====
// ----------------------------------------------------------------------------
// trt_checker
// Port-level checks of the texture residency table, bound to the top level.
// ----------------------------------------------------------------------------
module trt_checker import trt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [HANDLE_W-1:0] rsp_handle,
	input logic [TEX_W-1:0]    rsp_tid,
	input logic                rsp_last
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_handle) && $stable(rsp_tid) && $stable(rsp_last))
		else $error("stalled result changed");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_idle_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !rsp_valid)
		else $error("result pending while ready for a request");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
		else $error("result after the last one of a request");

	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STS_FAIL) |-> rsp_last)
		else $error("fail result not final");

endmodule

bind texture_residency_table_core trt_checker u_trt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_handle (rsp.out_handle),
	.rsp_tid    (rsp.out_texture_id),
	.rsp_last   (rsp.last)
);
